// ===== hdl/wf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wf_pkg
// Shared types, register codes and compare helpers for the 3x3 window filter.
// ----------------------------------------------------------------------------
package wf_pkg;

  typedef logic [7:0] pixel_t;

  // One window column: top row is two lines up, bottom row is the new pixel.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Per-column reductions that the filter core combines.
  typedef struct packed {
    pixel_t      lo;
    pixel_t      md;
    pixel_t      hi;
    logic [9:0]  sum;
    logic [7:0]  g_outer;
    logic [8:0]  g_center;
  } col_stats_t;

  typedef struct packed {
    logic valid;
    logic last;
  } wf_ctrl_t;

  typedef enum logic [1:0] {
    MODE_MEAN   = 2'd0,
    MODE_MEDIAN = 2'd1,
    MODE_GAUSS  = 2'd2
  } filter_mode_t;

  typedef enum logic [1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_index_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MODE_W      = 2;
  localparam int IMG_WIDTH_W = 11;
  localparam int IMG_HEIGHT_W = 16;

  localparam logic [MODE_W-1:0]       RESET_MODE   = MODE_MEAN;
  localparam logic [IMG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;

  // floor(x / 9) == (x * 7282) >> 16 for every nine-pixel sum (x <= 2295).
  localparam int              MEAN_SUM_W = 12;
  localparam int              MEAN_RECIP_W = 13;
  localparam logic [12:0]     MEAN_RECIP = 13'd7282;
  localparam int              MEAN_SHIFT = 16;

  function automatic pixel_t min2(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(input pixel_t a, input pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pixel_t min3(input pixel_t a, input pixel_t b, input pixel_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pixel_t max3(input pixel_t a, input pixel_t b, input pixel_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/wf_pixel_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wf_pixel_if
// Valid/ready channel that carries one grey input pixel per request.
// ----------------------------------------------------------------------------
interface wf_pixel_if;
  import wf_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface
`default_nettype wire

// ===== hdl/wf_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wf_result_if
// Valid/ready channel that carries one filtered pixel and its frame marker.
// ----------------------------------------------------------------------------
interface wf_result_if;
  import wf_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/wf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wf_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wf_line_store
// Two line RAMs that hold the rows one and two lines above the current pixel.
// ----------------------------------------------------------------------------
module wf_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wf_pkg::pixel_t           wr_pixel,
  output wf_pkg::pixel_t           up2,
  output wf_pkg::pixel_t           up1
);
  import wf_pkg::*;

  pixel_t a_q;
  pixel_t b_q;
  logic   hit;
  pixel_t fwd_a;
  pixel_t fwd_b;

  // Row two up takes what row one up held; row one up takes the new pixel.
  wf_ram #(.WIDTH($bits(pixel_t)), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (up1),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (a_q)
  );

  wf_ram #(.WIDTH($bits(pixel_t)), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (b_q)
  );

  // A read of the entry being written in the same cycle only happens on a
  // one-pixel row; the written values are forwarded in that case.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_a <= up1;
      fwd_b <= wr_pixel;
    end
  end

  assign up2 = hit ? fwd_a : a_q;
  assign up1 = hit ? fwd_b : b_q;

endmodule
`default_nettype wire

// ===== hdl/wf_column_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wf_column_cell
// One column of the 3x3 window: holds three pixels, passes them to its left
// neighbor on each shift and reduces them to sorted values and partial sums.
// ----------------------------------------------------------------------------
module wf_column_cell (
  input  logic               clk,
  input  logic               shift,
  input  wf_pkg::column_t    col_in,
  output wf_pkg::column_t    col_out,
  output wf_pkg::col_stats_t stats
);
  import wf_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
  end

  // Outer columns weight top and bottom by 1/4 and the middle by 1/2; the
  // center column weights top and bottom by 1/2 and the middle by 1.
  always_comb begin
    stats.lo       = min3(col_out.top, col_out.mid, col_out.bot);
    stats.md       = med3(col_out.top, col_out.mid, col_out.bot);
    stats.hi       = max3(col_out.top, col_out.mid, col_out.bot);
    stats.sum      = 10'(col_out.top) + 10'(col_out.mid) + 10'(col_out.bot);
    stats.g_outer  = 8'(col_out.top[7:2]) + 8'(col_out.mid[7:1]) + 8'(col_out.bot[7:2]);
    stats.g_center = 9'(col_out.top[7:1]) + 9'(col_out.mid) + 9'(col_out.bot[7:1]);
  end

endmodule
`default_nettype wire

// ===== hdl/wf_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wf_filter_core
// Combines the three column reductions into mean, median and weighted
// average, then scales the mean and selects by mode.
// ----------------------------------------------------------------------------
module wf_filter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [wf_pkg::MODE_W-1:0]    mode,
  input  wf_pkg::wf_ctrl_t             ctrl_in,
  input  wf_pkg::col_stats_t           left,
  input  wf_pkg::col_stats_t           center,
  input  wf_pkg::col_stats_t           right,
  output wf_pkg::wf_ctrl_t             ctrl_out,
  output wf_pkg::pixel_t               value
);
  import wf_pkg::*;

  logic [MEAN_SUM_W-1:0]                sum;
  pixel_t                               median;
  pixel_t                               gauss;
  logic [9:0]                           gauss_total;
  logic [MEAN_SUM_W+MEAN_RECIP_W-1:0]   mean_prod;

  // Median of nine from sorted columns: median of the largest low, the
  // middle mid and the smallest high.
  assign gauss_total = 10'(left.g_outer) + 10'(center.g_center) + 10'(right.g_outer);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (adv) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum    <= MEAN_SUM_W'(left.sum) + MEAN_SUM_W'(center.sum) + MEAN_SUM_W'(right.sum);
      median <= med3(max3(left.lo, center.lo, right.lo),
                     med3(left.md, center.md, right.md),
                     min3(left.hi, center.hi, right.hi));
      gauss  <= gauss_total[9:2];
    end
  end

  assign mean_prod = (MEAN_SUM_W+MEAN_RECIP_W)'(sum) * (MEAN_SUM_W+MEAN_RECIP_W)'(MEAN_RECIP);

  always_comb begin
    case (mode)
      MODE_MEAN:   value = mean_prod[MEAN_SHIFT +: 8];
      MODE_MEDIAN: value = median;
      MODE_GAUSS:  value = gauss;
      default:     value = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/window_filter_3x3.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_filter_3x3
// 3x3 mean / median / weighted-average filter over a raster pixel stream.
//
//   Channel  Role     Payload                   Handshake
//   pixels   sink     pixel_in                  valid / ready
//   results  source   pixel_out, frame_last     valid / ready
//   cfg      write    cfg_index, cfg_data       cfg_write, no wait
//
// Takes one pixel per clock and gives at most one result per clock.
// Each pixel passes line RAM stage, cells, filter core and output register;
// the line RAMs are read and written once per pixel, which fixes the rate.
// Reset clears the counters, pipeline valids and registers to their defaults;
// the line RAMs are not cleared and need no clearing pass.
// When the output register is full and not taken, the whole pipeline holds
// and pixels.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module window_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  wf_pixel_if.sink                      pixels,
  wf_result_if.source                   results,
  input  logic                          cfg_write,
  input  logic [wf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > IMG_WIDTH_W) ? CW + 1 : IMG_WIDTH_W;

  // Configuration
  logic [MODE_W-1:0]       mode;
  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;

  // Raster counters
  logic [CW-1:0]           col_count;
  logic [IMG_HEIGHT_W-1:0] row_count;
  logic [CW-1:0]           col_count_next;
  logic [IMG_HEIGHT_W-1:0] row_count_next;

  logic [WW-1:0]           width_ext;
  logic [WW-1:0]           width_eff;
  logic [WW-1:0]           col_plus;
  logic                    row_end;
  logic                    frame_end;
  logic                    emit;

  logic                    adv;
  logic                    accept;

  // Line RAM stage
  logic                    s1_valid;
  wf_ctrl_t                s1_ctrl;
  pixel_t                  s1_pixel;
  logic [CW-1:0]           s1_col;
  pixel_t                  up2;
  pixel_t                  up1;

  // Window chain
  column_t                 col_in  [3];
  column_t                 col_out [3];
  col_stats_t              stats   [3];
  logic                    shift;
  wf_ctrl_t                s2_ctrl;

  wf_ctrl_t                s3_ctrl;
  pixel_t                  s3_value;

  // Output register
  logic                    out_valid;
  pixel_t                  out_pixel;
  logic                    out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= RESET_MODE;
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILTER_MODE:  mode         <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv    = !out_valid || results.ready;
  assign accept = pixels.valid && adv;
  assign pixels.ready = adv;

  // A row ends when the next column reaches the width; a width of zero
  // behaves like one.
  always_comb begin
    width_ext = WW'(image_width);
    width_eff = (width_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : width_ext;
    col_plus  = WW'(col_count) + WW'(1);
    row_end   = col_plus >= width_eff;
    frame_end = row_end &&
                ((17'(row_count) + 17'd1) >= 17'(image_height));
    emit      = (row_count >= IMG_HEIGHT_W'(2)) && (col_count >= CW'(2)) &&
                (WW'(col_count) < width_eff) && (row_count < image_height);
    if (row_end) begin
      col_count_next = '0;
      row_count_next = frame_end ? '0 : row_count + IMG_HEIGHT_W'(1);
    end else begin
      col_count_next = col_plus[CW-1:0];
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel      <= pixels.pixel_in;
      s1_col        <= col_count;
      s1_ctrl.valid <= emit;
      s1_ctrl.last  <= frame_end;
    end
  end

  wf_line_store #(.DEPTH(MAX_WIDTH)) u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (col_count),
    .wr_en    (shift),
    .wr_addr  (s1_col),
    .wr_pixel (s1_pixel),
    .up2      (up2),
    .up1      (up1)
  );

  // The window moves one column left for every pixel, emitted or not.
  assign shift = adv && s1_valid;

  always_comb begin
    col_in[2] = '{top: up2, mid: up1, bot: s1_pixel};
    col_in[1] = col_out[2];
    col_in[0] = col_out[1];
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    wf_column_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .col_in  (col_in[k]),
      .col_out (col_out[k]),
      .stats   (stats[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
    end else if (adv) begin
      s2_ctrl.valid <= s1_valid && s1_ctrl.valid;
      s2_ctrl.last  <= s1_ctrl.last;
    end
  end

  wf_filter_core u_filter_core (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .mode     (mode),
    .ctrl_in  (s2_ctrl),
    .left     (stats[0]),
    .center   (stats[1]),
    .right    (stats[2]),
    .ctrl_out (s3_ctrl),
    .value    (s3_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel <= s3_value;
      out_last  <= s3_ctrl.last;
    end
  end

  assign results.valid      = out_valid;
  assign results.pixel_out  = out_pixel;
  assign results.frame_last = out_last;

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !pixels.ready)
    else $error("Input taken while the output register is stalled.");

  assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> ((row_count == '0) && (col_count == '0)))
    else $error("Counters did not restart after the last pixel of a frame.");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("Accepted pixel did not reach the line RAM stage.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s3_ctrl.valid))
    else $error("Result appeared without a filtered window behind it.");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_col) && $stable(s1_pixel)))
    else $error("Line RAM stage lost its pixel during a stall.");
`endif

endmodule
`default_nettype wire

// ===== tb/window_filter_3x3_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_filter_3x3_check
// Watches the pixel, result and register ports of the 3x3 window filter.
// Keeps its own line stores, window and counters, predicts each filtered
// pixel and compares it with what the block returns.
// ----------------------------------------------------------------------------
module window_filter_3x3_check #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  wf_pixel_if         pixels,
  wf_result_if        results,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          checked
);
  import wf_pkg::*;

  typedef struct packed {
    pixel_t value;
    logic   last;
  } filtered_t;

  filtered_t     filtered_q[$];

  filter_mode_t  cur_mode;
  logic [10:0]   cur_width;
  logic [15:0]   cur_height;
  pixel_t        row_two_up [MAX_WIDTH];
  pixel_t        row_one_up [MAX_WIDTH];
  pixel_t        win [9];
  int unsigned   col_pos;
  logic [15:0]   row_pos;

  function automatic pixel_t window_median();
    pixel_t v [9];
    pixel_t x;
    int     j;
    for (int i = 0; i < 9; i++) v[i] = win[i];
    for (int i = 1; i < 9; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j - 1] > x) begin
        v[j] = v[j - 1];
        j--;
      end
      v[j] = x;
    end
    return v[4];
  endfunction

  function automatic pixel_t window_value();
    int unsigned total;
    total = 0;
    case (cur_mode)
      MODE_MEAN: begin
        for (int i = 0; i < 9; i++) total += win[i];
        return pixel_t'(total / 9);
      end
      MODE_MEDIAN: begin
        return window_median();
      end
      MODE_GAUSS: begin
        // Each weighted term is truncated before the sum.
        total = win[0] / 4 + win[2] / 4 + win[6] / 4 + win[8] / 4;
        total += win[1] / 2 + win[3] / 2 + win[5] / 2 + win[7] / 2;
        total += win[4];
        return pixel_t'(total / 4);
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  function automatic void advance_window(input pixel_t px, output bit emit,
                                         output filtered_t res);
    int unsigned eff_w;
    int unsigned c;
    int unsigned r;
    pixel_t      up2;
    pixel_t      up1;
    bit          row_end;
    bit          frame_end;
    eff_w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
    c = col_pos;
    r = row_pos;
    up2 = '0;
    up1 = '0;
    if (c < MAX_WIDTH) begin
      up2 = row_two_up[c];
      up1 = row_one_up[c];
      row_two_up[c] = up1;
      row_one_up[c] = px;
    end
    for (int k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;
    row_end   = (c + 1 >= eff_w);
    frame_end = row_end && (r + 1 >= cur_height);
    emit = 1'b0;
    res  = '0;
    if (r >= 2 && c >= 2 && c < eff_w && r < cur_height) begin
      emit       = 1'b1;
      res.value  = window_value();
      res.last   = frame_end;
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 16'd0 : 16'(r + 1);
    end else begin
      col_pos = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    bit        emit;
    filtered_t want;
    filtered_t seen;
    if (rst) begin
      cur_mode   = MODE_MEAN;
      cur_width  = 11'd640;
      cur_height = 16'd480;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_two_up[i] = '0;
        row_one_up[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      col_pos = 0;
      row_pos = '0;
      filtered_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_FILTER_MODE:  cur_mode   = filter_mode_t'(cfg_data[1:0]);
          REG_IMAGE_WIDTH:  cur_width  = cfg_data[10:0];
          REG_IMAGE_HEIGHT: cur_height = cfg_data[15:0];
          default: ;
        endcase
      end
      // A result can never stem from a pixel taken at the same edge.
      if (results.valid && results.ready) begin
        seen.value = results.pixel_out;
        seen.last  = results.frame_last;
        checked++;
        if (filtered_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result pixel %0d last %0b", $realtime,
                     seen.value, seen.last);
        end else begin
          want = filtered_q.pop_front();
          if (want.value !== seen.value || want.last !== seen.last) begin
            fails++;
            if (fails <= 10)
              $display("%0t: result %0d expected pixel %0d last %0b, got pixel %0d last %0b",
                       $realtime, checked, want.value, want.last, seen.value, seen.last);
          end
        end
      end
      if (pixels.valid && pixels.ready) begin
        advance_window(pixels.pixel_in, emit, want);
        if (emit) filtered_q.push_back(want);
      end
    end
    pending = filtered_q.size();
  end

endmodule

// ===== tb/window_filter_3x3_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_filter_3x3_test
// Drives frames of pixels through the 3x3 window filter in every mode and
// over normal, narrow, oversized and resized frames, with random idling on
// both sides; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module window_filter_3x3_test;
  import wf_pkg::*;

  localparam int          MAX_W       = 1024;
  localparam int          SETTLE      = 12;
  localparam int          LIMIT       = 1000000;
  localparam int          RANDOM_PIX  = 120;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef enum int {
    PAT_RANDOM,
    PAT_BLACK,
    PAT_WHITE,
    PAT_CHECKER,
    PAT_RAMP,
    PAT_CLOSE
  } pattern_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fails;
  int          pending;
  int          checked;
  int          cycles;
  int          pixels_sent;
  int          frames_sent;
  int          hold_requests;
  int          holds_served;
  bit          gappy;

  wf_pixel_if  pix_ch ();
  wf_result_if res_ch ();

  window_filter_3x3 #(.MAX_WIDTH(MAX_W)) u_top (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .results   (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  window_filter_3x3_check #(.MAX_WIDTH(MAX_W)) u_check (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .results   (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, eager stretches, and long hold-offs on request.
  initial begin
    int unsigned phase_left;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          eager;
    phase_left   = 0;
    stall_left   = 0;
    hold_left    = 0;
    eager        = 1'b0;
    holds_served = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (holds_served < hold_requests && res_ch.valid) begin
        holds_served++;
        hold_left = $urandom_range(300, 600);
        res_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          eager      = ($urandom_range(0, 2) == 0);
          phase_left = $urandom_range(30, 300);
        end
        phase_left--;
        if (eager || stall_left == 0) begin
          res_ch.ready <= 1'b1;
          if (!eager) stall_left = idle_gap();
        end else begin
          stall_left--;
          res_ch.ready <= 1'b0;
        end
      end
    end
  end

  function automatic int unsigned frame_pixels(int unsigned width, int unsigned height);
    int unsigned eff_w;
    int unsigned eff_h;
    eff_w = (width > MAX_W) ? MAX_W : width;
    if (eff_w == 0) eff_w = 1;
    eff_h = (height == 0) ? 1 : height;
    return eff_w * eff_h;
  endfunction

  function automatic pixel_t pattern_pixel(pattern_t kind, int idx);
    case (kind)
      PAT_BLACK:   return 8'd0;
      PAT_WHITE:   return 8'd255;
      PAT_CHECKER: return idx[0] ? 8'd255 : 8'd0;
      PAT_RAMP:    return idx[7:0];
      PAT_CLOSE:   return 8'(100 + $urandom_range(0, 3));
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(reg_index_t idx, int unsigned value);
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only once every expected result has come back and the
  // pipeline has had time to drain pixels that give no result.
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_pixels(int n, pattern_t kind);
    int gap;
    for (int i = 0; i < n; i++) begin
      gap = gappy ? idle_gap() : 0;
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pix_ch.valid    <= 1'b1;
      pix_ch.pixel_in <= pattern_pixel(kind, i);
      @(posedge clk);
      while (!pix_ch.ready) @(posedge clk);
      @(negedge clk);
      pixels_sent++;
    end
    pix_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [1:0] mode, int unsigned width, int unsigned height);
    wait_idle();
    write_reg(REG_FILTER_MODE, mode);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
  endtask

  task automatic run_frame(logic [1:0] mode, int unsigned width, int unsigned height,
                           pattern_t kind);
    configure(mode, width, height);
    gappy = ($urandom_range(0, 3) != 0);
    send_pixels(frame_pixels(width, height), kind);
    frames_sent++;
  endtask

  task automatic random_frame();
    logic [1:0]  mode;
    int unsigned width;
    int unsigned height;
    int unsigned total;
    int unsigned split;
    pattern_t    kind;
    mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 19))
      0: begin
        width  = $urandom_range(0, 2);
        height = $urandom_range(1, 6);
      end
      1: begin
        width  = $urandom_range(1, 10);
        height = $urandom_range(0, 2);
      end
      2, 3: begin
        width  = $urandom_range(13, 64);
        height = $urandom_range(3, 5);
      end
      default: begin
        width  = $urandom_range(3, 12);
        height = $urandom_range(3, 8);
      end
    endcase
    case ($urandom_range(0, 9))
      0:       kind = PAT_CLOSE;
      1:       kind = PAT_CHECKER;
      default: kind = PAT_RANDOM;
    endcase
    total = frame_pixels(width, height);
    if (total > 1 && $urandom_range(0, 3) == 0) begin
      // Pause mid-frame and switch the filter before the rest of the frame.
      configure(mode, width, height);
      gappy = ($urandom_range(0, 3) != 0);
      split = $urandom_range(1, total - 1);
      send_pixels(split, kind);
      wait_idle();
      write_reg(REG_FILTER_MODE, 2'($urandom_range(0, 3)));
      send_pixels(total - split, kind);
      frames_sent++;
    end else begin
      run_frame(mode, width, height, kind);
    end
  endtask

  initial begin
    int random_start;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    pixels_sent     = 0;
    frames_sent     = 0;
    hold_requests   = 0;
    gappy           = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Smallest frames with flat and extreme content in every mode.
    run_frame(MODE_MEAN, 3, 3, PAT_WHITE);
    run_frame(MODE_MEAN, 3, 3, PAT_BLACK);
    run_frame(MODE_MEDIAN, 4, 4, PAT_CHECKER);
    run_frame(MODE_MEDIAN, 4, 3, PAT_CLOSE);
    run_frame(MODE_GAUSS, 5, 3, PAT_WHITE);
    run_frame(MODE_GAUSS, 5, 4, PAT_RANDOM);
    run_frame(MODE_UNUSED, 4, 3, PAT_RANDOM);

    // Frames too narrow or too short to ever fill a window, then a 3x3 ramp.
    run_frame(MODE_MEAN, 2, 5, PAT_RANDOM);
    run_frame(MODE_MEAN, 0, 4, PAT_RANDOM);
    run_frame(MODE_MEDIAN, 1, 3, PAT_RANDOM);
    run_frame(MODE_GAUSS, 6, 2, PAT_RANDOM);
    run_frame(MODE_GAUSS, 5, 0, PAT_RANDOM);
    run_frame(MODE_MEAN, 3, 1, PAT_RANDOM);
    run_frame(MODE_MEDIAN, 3, 3, PAT_RAMP);

    // Height set to its maximum, then the mode and a lower height mid-frame;
    // the row count past the new bound wraps at the end of its row.
    configure(MODE_MEAN, 3, 16'hFFFF);
    gappy = 1'b1;
    send_pixels(12, PAT_RANDOM);
    wait_idle();
    write_reg(REG_FILTER_MODE, MODE_MEDIAN);
    send_pixels(6, PAT_RANDOM);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_pixels(3, PAT_RANDOM);
    frames_sent++;

    // Width lowered mid-row: the column count past the new bound wraps.
    configure(MODE_GAUSS, 8, 5);
    send_pixels(21, PAT_RANDOM);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 4);
    send_pixels(9, PAT_RANDOM);
    frames_sent++;

    // Oversized width acts as the full line length: the first row ends after
    // that many pixels, then the width drops to eight for the last two rows.
    configure(MODE_MEDIAN, 11'h7FF, 3);
    gappy = 1'b0;
    send_pixels(MAX_W, PAT_RANDOM);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 8);
    send_pixels(16, PAT_RANDOM);
    frames_sent++;

    // The result side holds off for a long stretch so that the block fills
    // up and stalls its input.
    hold_requests++;
    run_frame(MODE_GAUSS, 24, 4, PAT_RANDOM);
    run_frame(MODE_MEAN, 3, 3, PAT_RANDOM);

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIX) begin
      if (frames_sent % 12 == 5) hold_requests++;
      random_frame();
    end

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d pixels in %0d frames over all four mode codes, widths 0 to 2047,",
             pixels_sent, frames_sent);
    $display("mid-frame register changes and %0d long output hold-offs; %0d results compared.",
             holds_served, checked);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
